/* rtl/ole_pkg.sv */
`timescale 1ns / 1ps

package ole_pkg;

	localparam int KEY_W = 32;
	localparam int OP_W  = 4;

	// operation codes carried in s_tuser
	localparam logic [OP_W-1:0] OP_INS_FRONT  = 4'd0;
	localparam logic [OP_W-1:0] OP_INS_BACK   = 4'd1;
	localparam logic [OP_W-1:0] OP_INS_SORTED = 4'd2;
	localparam logic [OP_W-1:0] OP_REM_FRONT  = 4'd3;
	localparam logic [OP_W-1:0] OP_REM_BACK   = 4'd4;
	localparam logic [OP_W-1:0] OP_REM_KEY    = 4'd5;
	localparam logic [OP_W-1:0] OP_MEMBER     = 4'd6;
	localparam logic [OP_W-1:0] OP_ITER_START = 4'd7;
	localparam logic [OP_W-1:0] OP_ITER_NEXT  = 4'd8;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_EXEC
	} state_t;

	// per-cell shift control
	typedef struct packed {
		logic load_new;
		logic take_left;
		logic take_right;
	} cell_ctrl_t;

endpackage

/* rtl/ole_cell.sv */
`timescale 1ns / 1ps

module ole_cell (
	input  logic                                clk,
	input  ole_pkg::cell_ctrl_t                 ctrl,
	input  logic signed [ole_pkg::KEY_W-1:0]    probe_key,
	input  logic signed [ole_pkg::KEY_W-1:0]    left_key,
	input  logic signed [ole_pkg::KEY_W-1:0]    right_key,
	output logic signed [ole_pkg::KEY_W-1:0]    entry,
	output logic                                eq,
	output logic                                lt
);
	import ole_pkg::*;

	logic signed [KEY_W-1:0] entry_q;
	logic                    eq_q;
	logic                    lt_q;

	// entry storage: load, shift right from left neighbor or shift left from right neighbor
	always_ff @(posedge clk) begin
		if (ctrl.load_new) begin
			entry_q <= probe_key;
		end else if (ctrl.take_left) begin
			entry_q <= left_key;
		end else if (ctrl.take_right) begin
			entry_q <= right_key;
		end
	end

	// registered compare against the probe key
	always_ff @(posedge clk) begin
		eq_q <= (entry_q == probe_key);
		lt_q <= (entry_q < probe_key);
	end

	assign entry = entry_q;
	assign eq    = eq_q;
	assign lt    = lt_q;

endmodule

/* rtl/ordered_list_engine.sv */
`timescale 1ns / 1ps
// an accepted word goes through the compare state and the shift state into the output register
// the next word is taken in the shift state of the previous one, not in its compare state
// a waiting result word does not block the next input word until its own shift cycle
// reset clears the entry count, the iterator and all handshake state; stored keys are undefined

module ordered_list_engine #(
	parameter int CAPACITY = 64
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// key_in[31:0]
	input  logic [ole_pkg::KEY_W-1:0]              s_tdata,
	// opcode[3:0]
	input  logic [ole_pkg::OP_W-1:0]               s_tuser,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// ok[0], key_out[32:1], count[32+CW:33], more[33+CW], zero fill up to byte
	output logic [((ole_pkg::KEY_W + 2 + $clog2(CAPACITY + 1) + 7) / 8) * 8 - 1:0] m_tdata
);
	import ole_pkg::*;

	localparam int CW    = $clog2(CAPACITY + 1);
	localparam int IW    = $clog2(CAPACITY);
	localparam int RES_W = KEY_W + 2 + CW;
	localparam int OUT_W = ((RES_W + 7) / 8) * 8;

	state_t state_q, state_d;

	logic [OP_W-1:0]         op_q;
	logic signed [KEY_W-1:0] key_q;
	logic [CW-1:0]           count_q;
	logic [IW-1:0]           iter_q;
	logic                    m_tvalid_q;
	logic [OUT_W-1:0]        m_tdata_q;

	logic in_fire;
	logic out_free;
	logic exec_fire;

	logic signed [KEY_W-1:0] cell_key [CAPACITY];
	logic [CAPACITY-1:0]     eq_v;
	logic [CAPACITY-1:0]     lt_v;
	cell_ctrl_t              ctrl_v [CAPACITY];

	logic [CAPACITY-1:0] valid_v;
	logic [CAPACITY-1:0] at_count_v;
	logic [CAPACITY-1:0] at_last_v;
	logic [CAPACITY-1:0] match_v;
	logic [CAPACITY-1:0] cand_v;
	logic [CAPACITY-1:0] iter_v;
	logic [CAPACITY-1:0] sel_v;
	logic [CAPACITY-1:0] pos_v;
	logic [CAPACITY-1:0] pick_v;

	logic          full;
	logic          empty;
	logic          found;
	logic          ins_go;
	logic          rem_go;
	logic          res_ok;
	logic          res_more;
	logic [KEY_W-1:0] res_key;
	logic [CW-1:0] count_d;
	logic [IW-1:0] iter_d;
	logic [IW-1:0] iter_idx;
	logic [CW-1:0] count_m1;

	// handshake state machine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		exec_fire = 1'b0;
		out_free  = !m_tvalid_q || m_tready;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) state_d = ST_CMP;
			end
			ST_CMP: begin
				state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (out_free) begin
					exec_fire = 1'b1;
					s_tready  = 1'b1;
					state_d   = s_tvalid ? ST_CMP : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign in_fire = s_tvalid && s_tready;

	// input word capture
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q  <= s_tuser;
			key_q <= s_tdata;
		end
	end

	// row of cells, each shifting with its neighbors
	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			logic signed [KEY_W-1:0] left_k;
			logic signed [KEY_W-1:0] right_k;

			if (gi == 0) begin : g_head
				assign left_k = '0;
			end else begin : g_mid
				assign left_k = cell_key[gi-1];
			end
			if (gi == CAPACITY - 1) begin : g_tail
				assign right_k = '0;
			end else begin : g_body
				assign right_k = cell_key[gi+1];
			end

			ole_cell u_cell (
				.clk       (clk),
				.ctrl      (ctrl_v[gi]),
				.probe_key (key_q),
				.left_key  (left_k),
				.right_key (right_k),
				.entry     (cell_key[gi]),
				.eq        (eq_v[gi]),
				.lt        (lt_v[gi])
			);

			// per-cell position flags
			assign valid_v[gi]    = (CW'(gi) < count_q);
			assign at_count_v[gi] = (CW'(gi) == count_q);
			assign at_last_v[gi]  = !empty && (CW'(gi) == count_m1);
			assign iter_v[gi]     = (IW'(gi) == iter_idx);
			assign match_v[gi]    = eq_v[gi] && valid_v[gi];
			if (gi == 0) begin : g_cand0
				assign cand_v[gi] = 1'b0;
			end else begin : g_candn
				assign cand_v[gi] = valid_v[gi] && !lt_v[gi];
			end

			// shift control from the first-position mask
			if (gi == 0) begin : g_ctl0
				assign ctrl_v[gi].load_new   = exec_fire && ins_go && pos_v[gi];
				assign ctrl_v[gi].take_left  = 1'b0;
			end else begin : g_ctln
				assign ctrl_v[gi].load_new   = exec_fire && ins_go && pos_v[gi] && !pos_v[gi-1];
				assign ctrl_v[gi].take_left  = exec_fire && ins_go && pos_v[gi-1];
			end
			assign ctrl_v[gi].take_right = exec_fire && rem_go && pos_v[gi];
		end
	endgenerate

	assign full     = (count_q == CW'(CAPACITY));
	assign empty    = (count_q == '0);
	assign found    = |match_v;
	assign count_m1 = count_q - CW'(1);
	assign iter_idx = (CW'(iter_q) >= count_q) ? '0 : iter_q;

	// operation decode: start position, result flags
	always_comb begin
		sel_v    = '0;
		pick_v   = '0;
		ins_go   = 1'b0;
		rem_go   = 1'b0;
		res_ok   = 1'b0;
		res_more = 1'b0;
		case (op_q)
			OP_INS_FRONT: begin
				ins_go   = !full;
				res_ok   = !full;
				sel_v[0] = 1'b1;
			end
			OP_INS_BACK: begin
				ins_go = !full;
				res_ok = !full;
				sel_v  = at_count_v;
			end
			OP_INS_SORTED: begin
				ins_go = !full;
				res_ok = !full;
				if (empty || (!lt_v[0] && !eq_v[0])) begin
					sel_v[0] = 1'b1;
				end else begin
					sel_v = cand_v | at_count_v;
				end
			end
			OP_REM_FRONT: begin
				rem_go    = !empty;
				res_ok    = !empty;
				sel_v[0]  = 1'b1;
				pick_v[0] = !empty;
			end
			OP_REM_BACK: begin
				rem_go = !empty;
				res_ok = !empty;
				sel_v  = at_last_v;
				pick_v = at_last_v;
			end
			OP_REM_KEY: begin
				rem_go = found;
				res_ok = found;
				sel_v  = match_v;
			end
			OP_MEMBER: begin
				res_ok = found;
			end
			OP_ITER_START: begin
				res_ok = !empty;
			end
			OP_ITER_NEXT: begin
				res_ok   = !empty;
				res_more = !empty && ((CW'(iter_idx) + CW'(1)) < count_q);
				if (!empty) pick_v = iter_v;
			end
			default: begin
				res_ok = 1'b0;
			end
		endcase
	end

	// first selected position and everything after it, log-depth prefix or
	always_comb begin
		pos_v = sel_v;
		for (int s = 1; s < CAPACITY; s = s * 2) begin
			pos_v = pos_v | (pos_v << s);
		end
	end

	// and-or read of the picked cell
	always_comb begin
		res_key = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			res_key = res_key | (pick_v[i] ? cell_key[i] : '0);
		end
	end

	// next count and iterator
	always_comb begin
		count_d = count_q;
		iter_d  = iter_q;
		if (ins_go) count_d = count_q + CW'(1);
		if (rem_go) count_d = count_q - CW'(1);
		if (ins_go || rem_go || op_q == OP_ITER_START) begin
			iter_d = '0;
		end else if (op_q == OP_ITER_NEXT && !empty) begin
			iter_d = res_more ? (iter_idx + IW'(1)) : iter_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			iter_q  <= '0;
		end else if (exec_fire) begin
			count_q <= count_d;
			iter_q  <= iter_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (exec_fire) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_fire) begin
			m_tdata_q <= OUT_W'({res_more, count_d, res_key, res_ok});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

/* bench/tb_ordered_list_engine.sv */
`timescale 1ns / 1ps

module tb_ordered_list_engine;
	import ole_pkg::*;

	localparam int LIST_CAP = 64;
	localparam int CNT_W    = $clog2(LIST_CAP + 1);
	localparam int OUT_W    = ((KEY_W + 2 + CNT_W + 7) / 8) * 8;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_WORDS = 440;
	localparam int MAX_REPORTS = 40;

	// opcodes the block leaves without effect
	localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 4'd9;
	localparam logic [OP_W-1:0] OP_UNUSED_LAST  = 4'd15;

	localparam logic [KEY_W-1:0] KEY_MIN = 32'h8000_0000;
	localparam logic [KEY_W-1:0] KEY_MAX = 32'h7fff_ffff;
	localparam logic [KEY_W-1:0] KEY_NEG_ONE = 32'hffff_ffff;

	typedef struct packed {
		logic             ok;
		logic [KEY_W-1:0] key;
		logic [CNT_W-1:0] count;
		logic             more;
	} list_result_t;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [KEY_W-1:0]  s_tdata;
	logic [OP_W-1:0]   s_tuser;
	logic              m_tvalid;
	logic              m_tready;
	logic [OUT_W-1:0]  m_tdata;

	ordered_list_engine #(
		.CAPACITY(LIST_CAP)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	// shadow copy of the list, head at index 0
	logic [KEY_W-1:0] list_keys[$];
	int unsigned      iter_idx;
	list_result_t     expected_results[$];

	int send_idle_pct;
	int stall_pct;
	int error_count;
	int words_sent;
	int results_checked;
	int full_rejects;
	int empty_rejects;
	int cycle_count;

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				expected_results.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// receiver back-pressure
	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// next list state and result word for one accepted word
	function automatic list_result_t apply_op(input logic [OP_W-1:0] op,
			input logic [KEY_W-1:0] key);
		list_result_t res;
		int           pos;
		bit           full;
		res  = '0;
		full = (list_keys.size() >= LIST_CAP);
		case (op)
			OP_INS_FRONT, OP_INS_BACK, OP_INS_SORTED: begin
				if (full) begin
					full_rejects++;
				end else begin
					if (op == OP_INS_FRONT) begin
						pos = 0;
					end else if (op == OP_INS_BACK) begin
						pos = list_keys.size();
					end else if (list_keys.size() == 0 ||
							$signed(key) < $signed(list_keys[0])) begin
						pos = 0;
					end else begin
						// the head is skipped, placement starts at the second entry
						pos = 1;
						while (pos < list_keys.size() &&
								$signed(list_keys[pos]) < $signed(key))
							pos++;
					end
					if (pos == list_keys.size())
						list_keys.push_back(key);
					else
						list_keys.insert(pos, key);
					iter_idx = 0;
					res.ok   = 1'b1;
				end
			end
			OP_REM_FRONT, OP_REM_BACK: begin
				if (list_keys.size() == 0) begin
					empty_rejects++;
				end else begin
					res.key  = (op == OP_REM_FRONT) ? list_keys.pop_front() :
						list_keys.pop_back();
					iter_idx = 0;
					res.ok   = 1'b1;
				end
			end
			OP_REM_KEY, OP_MEMBER: begin
				for (pos = 0; pos < list_keys.size(); pos++) begin
					if (list_keys[pos] == key)
						break;
				end
				if (pos < list_keys.size()) begin
					res.ok = 1'b1;
					if (op == OP_REM_KEY) begin
						list_keys.delete(pos);
						iter_idx = 0;
					end
				end
			end
			OP_ITER_START: begin
				iter_idx = 0;
				res.ok   = (list_keys.size() > 0);
			end
			OP_ITER_NEXT: begin
				if (list_keys.size() > 0) begin
					if (iter_idx >= list_keys.size())
						iter_idx = 0;
					res.key = list_keys[iter_idx];
					res.ok  = 1'b1;
					if (iter_idx + 1 < list_keys.size()) begin
						iter_idx++;
						res.more = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
		res.count = CNT_W'(list_keys.size());
		return res;
	endfunction

	// one word on the input side, called and left at a falling edge
	task automatic send_word(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			s_tuser  <= OP_W'($urandom());
			s_tdata  <= $urandom();
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= key;
		do
			@(posedge clk);
		while (!s_tready);
		expected_results.push_back(apply_op(op, key));
		words_sent++;
		@(negedge clk);
	endtask

	task automatic hold_input_idle();
		s_tvalid <= 1'b0;
		@(negedge clk);
	endtask

	// keys biased toward repeats, extremes and stored values
	function automatic logic [KEY_W-1:0] pick_key();
		case ($urandom_range(0, 3))
			0: return $urandom();
			1: return $urandom_range(0, 8) - 4;
			2: begin
				case ($urandom_range(0, 3))
					0: return KEY_MIN;
					1: return KEY_MAX;
					2: return KEY_NEG_ONE;
					default: return '0;
				endcase
			end
			default: begin
				if (list_keys.size() == 0)
					return $urandom();
				return list_keys[$urandom_range(0, list_keys.size() - 1)];
			end
		endcase
	endfunction

	task automatic check_field(input string name, input logic [KEY_W-1:0] want,
			input logic [KEY_W-1:0] got);
		if (want !== got) begin
			error_count++;
			if (error_count <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	// result word checker
	always @(posedge clk) begin : result_check
		list_result_t want;
		list_result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.ok    = m_tdata[0];
			got.key   = m_tdata[KEY_W:1];
			got.count = m_tdata[KEY_W+CNT_W:KEY_W+1];
			got.more  = m_tdata[KEY_W+CNT_W+1];
			if (expected_results.size() == 0) begin
				error_count++;
				if (error_count <= MAX_REPORTS)
					$display("%0t: unexpected result word %0h, expected none", $time, m_tdata);
			end else begin
				want = expected_results.pop_front();
				check_field("ok", KEY_W'(want.ok), KEY_W'(got.ok));
				check_field("key_out", want.key, got.key);
				check_field("count", KEY_W'(want.count), KEY_W'(got.count));
				check_field("more", KEY_W'(want.more), KEY_W'(got.more));
				check_field("fill", '0, KEY_W'(m_tdata[OUT_W-1:KEY_W+CNT_W+2]));
				results_checked++;
			end
		end
	end

	// every remove, lookup and iterator operation against an empty list, unused opcodes included
	task automatic test_empty_list();
		send_word(OP_REM_FRONT, $urandom());
		send_word(OP_REM_BACK, $urandom());
		send_word(OP_REM_KEY, '0);
		send_word(OP_MEMBER, '0);
		send_word(OP_ITER_START, $urandom());
		send_word(OP_ITER_NEXT, $urandom());
		send_word(OP_UNUSED_FIRST, KEY_MAX);
		send_word(OP_UNUSED_LAST, KEY_MIN);
	endtask

	// extreme keys, lookups, iterator walk past the tail, removal of the last entry
	task automatic test_edge_keys();
		send_word(OP_INS_BACK, KEY_MAX);
		send_word(OP_INS_FRONT, KEY_MIN);
		send_word(OP_INS_BACK, '0);
		send_word(OP_INS_FRONT, KEY_NEG_ONE);
		send_word(OP_MEMBER, KEY_MIN);
		send_word(OP_MEMBER, 32'd1);
		send_word(OP_REM_KEY, 32'd5);
		send_word(OP_ITER_START, '0);
		repeat (5) send_word(OP_ITER_NEXT, $urandom());
		send_word(OP_REM_FRONT, $urandom());
		send_word(OP_REM_KEY, KEY_MAX);
		send_word(OP_REM_BACK, $urandom());
		send_word(OP_REM_BACK, $urandom());
	endtask

	// sorted placement: head only when the head is greater, else from the second entry
	task automatic test_sorted_placement();
		send_word(OP_INS_SORTED, 32'd10);
		send_word(OP_INS_SORTED, 32'd20);
		send_word(OP_INS_SORTED, 32'd5);
		send_word(OP_INS_SORTED, 32'd10);
		send_word(OP_INS_FRONT, 32'd100);
		send_word(OP_INS_SORTED, 32'd60);
		send_word(OP_INS_SORTED, KEY_MIN);
		send_word(OP_INS_SORTED, KEY_MAX);
	endtask

	// fill to capacity, rejected inserts, then drain to empty
	task automatic test_full_list();
		while (list_keys.size() < LIST_CAP)
			send_word(OP_W'($urandom_range(OP_INS_FRONT, OP_INS_SORTED)), pick_key());
		send_word(OP_INS_FRONT, $urandom());
		send_word(OP_INS_BACK, $urandom());
		send_word(OP_INS_SORTED, $urandom());
		send_word(OP_MEMBER, pick_key());
		send_word(OP_ITER_START, '0);
		send_word(OP_ITER_NEXT, '0);
		while (list_keys.size() > 0)
			send_word(OP_W'($urandom_range(OP_REM_FRONT, OP_REM_KEY)), pick_key());
		send_word(OP_REM_KEY, pick_key());
	endtask

	// random mix, alternating fill-heavy and drain-heavy stretches
	task automatic test_random_mix(input int idle_pct, input int stall);
		int sent;
		int pick;
		int ins_bias;
		send_idle_pct = idle_pct;
		stall_pct     = stall;
		sent = 0;
		while (sent < PHASE_WORDS) begin
			ins_bias = ((sent / 120) % 2) ? 30 : 70;
			pick = $urandom_range(0, 99);
			if (pick < 3) begin
				send_word(OP_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST)), $urandom());
				sent++;
			end else if (pick < 9) begin
				send_word(OP_ITER_START, $urandom());
				sent++;
				repeat ($urandom_range(1, 8)) begin
					send_word(OP_ITER_NEXT, $urandom());
					sent++;
				end
			end else if (pick < 9 + (91 * ins_bias) / 100) begin
				send_word(OP_W'($urandom_range(OP_INS_FRONT, OP_INS_SORTED)), pick_key());
				sent++;
			end else begin
				send_word(OP_W'($urandom_range(OP_REM_FRONT, OP_MEMBER)), pick_key());
				sent++;
			end
		end
	endtask

	initial begin
		arst_n          = 1'b0;
		s_tvalid        = 1'b0;
		s_tdata         = '0;
		s_tuser         = '0;
		m_tready        = 1'b0;
		send_idle_pct   = 0;
		stall_pct       = 0;
		error_count     = 0;
		words_sent      = 0;
		results_checked = 0;
		full_rejects    = 0;
		empty_rejects   = 0;
		cycle_count     = 0;
		iter_idx        = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_empty_list();
		test_edge_keys();
		test_sorted_placement();
		test_full_list();
		test_random_mix(0, 0);
		test_random_mix(76, 0);
		test_random_mix(0, 76);
		test_random_mix(28, 28);
		hold_input_idle();

		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("covered %0d words: every opcode, extreme keys, full and empty list,",
			words_sent);
		$display("%0d results checked, %0d inserts refused when full, %0d removes on empty",
			results_checked, full_rejects, empty_rejects);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
